>>> rtl/mouse_motion_coalescer_top_assert.svh
// ----------------------------------------------------------------------------
// mouse motion coalescer assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef MOUSE_MOTION_COALESCER_TOP_ASSERT_SVH
`define MOUSE_MOTION_COALESCER_TOP_ASSERT_SVH

// same-cycle implication
`define MMC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mmc assertion failed");

// next-cycle implication
`define MMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mmc assertion failed");

`endif

>>> rtl/mmc_pkg.sv
// ----------------------------------------------------------------------------
// mmc_pkg
// types and constants of the mouse motion coalescer
// ----------------------------------------------------------------------------
`default_nettype none

package mmc_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_SEND  = 2'd1,
    CMD_CLEAR = 2'd2
  } mmc_cmd_e;

  localparam logic [7:0]         BUTTON_MASK = 8'h1F;
  localparam logic signed [15:0] XY_LIMIT    = 16'sd32767;
  localparam logic signed [7:0]  WHEEL_LIMIT = 8'sd127;
  localparam logic signed [31:0] RES_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] RES_MIN     = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic signed [7:0]  scroll;
    logic [7:0]         button_byte;
    logic               link_connected;
    logic               link_accepts;
  } mmc_in_t;

  typedef struct packed {
    logic [4:0]         report_buttons;
    logic signed [15:0] report_x;
    logic signed [15:0] report_y;
    logic signed [7:0]  report_scroll;
    logic [6:0]         events_consumed;
  } mmc_out_t;

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [7:0]  wheel;
    logic [4:0]         buttons;
    logic               changed;
  } mmc_entry_t;

endpackage

`default_nettype wire

>>> rtl/mouse_motion_coalescer_top.sv
// ----------------------------------------------------------------------------
// mouse_motion_coalescer_top
// ring of mouse events folded into clamped reports on send ticks
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken on a rising edge with start high and busy low.
//   Push and clear items, and send ticks that find the link disconnected
//   or the ring empty, finish without leaving idle; busy stays low.
//   A send tick over N queued events walks the ring through the memory
//   read port, one entry per cycle, then clamps the sums and finishes; busy is
//   high meanwhile. The walk length, set by the single registered read
//   port and the shared accumulator, bounds the rate of send ticks.
//   If the tick saw motion or a button change, the report appears on
//   result_o with result_valid_o high for exactly one cycle, the same
//   cycle in which busy falls. The receiver cannot stall; the strobe is not held.
//   A new item may be started in the same cycle the report is shown.
//   Reset empties the ring and zeroes residuals and button history; the
//   event memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module mouse_motion_coalescer_top #(
  parameter int RING_DEPTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire mmc_pkg::mmc_in_t item_i,
  output logic                  result_valid_o,
  output mmc_pkg::mmc_out_t     result_o
);

  import mmc_pkg::*;

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int OCC_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = 33 + OCC_W;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(RING_DEPTH);

  localparam logic signed [SUM_W-1:0] XY_HI = SUM_W'(XY_LIMIT);
  localparam logic signed [SUM_W-1:0] XY_LO = -SUM_W'(XY_LIMIT);
  localparam logic signed [SUM_W-1:0] WH_HI = SUM_W'(WHEEL_LIMIT);
  localparam logic signed [SUM_W-1:0] WH_LO = -SUM_W'(WHEEL_LIMIT);
  localparam logic signed [SUM_W-1:0] RS_HI = SUM_W'(RES_MAX);
  localparam logic signed [SUM_W-1:0] RS_LO = SUM_W'(RES_MIN);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WALK   = 4'b0010,
    S_CLAMP  = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] nxt;
    nxt = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    return nxt;
  endfunction

  function automatic logic signed [15:0] clamp_xy(input logic signed [SUM_W-1:0] v);
    logic signed [15:0] c;
    if (v > XY_HI) begin
      c = XY_LIMIT;
    end else if (v < XY_LO) begin
      c = -XY_LIMIT;
    end else begin
      c = v[15:0];
    end
    return c;
  endfunction

  function automatic logic signed [7:0] clamp_wh(input logic signed [SUM_W-1:0] v);
    logic signed [7:0] c;
    if (v > WH_HI) begin
      c = WHEEL_LIMIT;
    end else if (v < WH_LO) begin
      c = -WHEEL_LIMIT;
    end else begin
      c = v[7:0];
    end
    return c;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > RS_HI) begin
      r = RES_MAX;
    end else if (v < RS_LO) begin
      r = RES_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // control state
  state_e             state_q, state_d;
  logic [PTR_W-1:0]   wp_q, wp_d, rp_q, rp_d, p_q, p_d;
  logic [OCC_W-1:0]   occ_q, occ_d, cnt_q, cnt_d;
  logic signed [31:0] res_x_q, res_x_d, res_y_q, res_y_d, res_w_q, res_w_d;
  logic [4:0]         sent_q, sent_d;
  logic [7:0]         last_q, last_d;
  logic               rvalid_q, rvalid_d;
  logic               valid_q, valid_d;
  logic               accepts_q, accepts_d;
  logic               moved_q, moved_d, chg_q, chg_d;

  // datapath
  logic signed [SUM_W-1:0] sx_q, sx_d, sy_q, sy_d, sw_q, sw_d;
  logic [4:0]              btn_q, btn_d;
  logic signed [15:0]      cx_q, cx_d, cy_q, cy_d;
  logic signed [7:0]       cw_q, cw_d;
  mmc_out_t                result_q, result_d;
  logic [OCC_W+6:0]        occ_ext;

  // event memory
  mmc_entry_t ring_q [RING_DEPTH];
  mmc_entry_t rdata_q;
  mmc_entry_t wdata;
  logic       mem_we;

  logic accept;
  logic issue;

  assign accept  = start && state_q == S_IDLE;
  assign issue   = cnt_q != occ_q;
  assign occ_ext = (OCC_W + 7)'(occ_q);

  assign wdata.dx      = item_i.move_x;
  assign wdata.dy      = item_i.move_y;
  assign wdata.wheel   = item_i.scroll;
  assign wdata.buttons = 5'(item_i.button_byte & BUTTON_MASK);
  assign wdata.changed = item_i.button_byte != last_q;

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    p_d       = p_q;
    occ_d     = occ_q;
    cnt_d     = cnt_q;
    res_x_d   = res_x_q;
    res_y_d   = res_y_q;
    res_w_d   = res_w_q;
    sent_d    = sent_q;
    last_d    = last_q;
    rvalid_d  = 1'b0;
    valid_d   = 1'b0;
    accepts_d = accepts_q;
    moved_d   = moved_q;
    chg_d     = chg_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    sw_d      = sw_q;
    btn_d     = btn_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    cw_d      = cw_q;
    result_d  = result_q;
    mem_we    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (item_i.command)
            CMD_PUSH: begin
              mem_we = 1'b1;
              last_d = item_i.button_byte;
              wp_d   = advance(wp_q);
              if (occ_q != OCC_FULL) begin
                occ_d = occ_q + OCC_W'(1);
              end else begin
                rp_d = advance(rp_q);
              end
            end
            CMD_SEND: begin
              if (item_i.link_connected && occ_q != '0) begin
                sx_d      = SUM_W'(res_x_q);
                sy_d      = SUM_W'(res_y_q);
                sw_d      = SUM_W'(res_w_q);
                btn_d     = sent_q;
                moved_d   = 1'b0;
                chg_d     = 1'b0;
                p_d       = rp_q;
                cnt_d     = '0;
                accepts_d = item_i.link_accepts;
                state_d   = S_WALK;
              end
            end
            CMD_CLEAR: begin
              wp_d    = '0;
              rp_d    = '0;
              occ_d   = '0;
              res_x_d = '0;
              res_y_d = '0;
              res_w_d = '0;
              sent_d  = '0;
              last_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        rvalid_d = issue;
        if (issue) begin
          p_d   = advance(p_q);
          cnt_d = cnt_q + OCC_W'(1);
        end
        if (rvalid_q) begin
          sx_d  = sx_q + SUM_W'(rdata_q.dx);
          sy_d  = sy_q + SUM_W'(rdata_q.dy);
          sw_d  = sw_q + SUM_W'(rdata_q.wheel);
          btn_d = rdata_q.buttons;
          chg_d = chg_q || rdata_q.changed;
          if (rdata_q.dx != '0 || rdata_q.dy != '0 || rdata_q.wheel != '0) begin
            moved_d = 1'b1;
          end
        end
        if (!issue && !rvalid_q) begin
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cx_d    = clamp_xy(sx_q);
        cy_d    = clamp_xy(sy_q);
        cw_d    = clamp_wh(sw_q);
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (moved_q || chg_q) begin
          valid_d                  = 1'b1;
          result_d.report_buttons  = btn_q;
          result_d.report_x        = cx_q;
          result_d.report_y        = cy_q;
          result_d.report_scroll   = cw_q;
          result_d.events_consumed = occ_ext[6:0];
          if (accepts_q) begin
            res_x_d = sat32(sx_q - SUM_W'(cx_q));
            res_y_d = sat32(sy_q - SUM_W'(cy_q));
            res_w_d = sat32(sw_q - SUM_W'(cw_q));
            sent_d  = btn_q;
            rp_d    = wp_q;
            occ_d   = '0;
          end
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wp_q      <= '0;
      rp_q      <= '0;
      p_q       <= '0;
      occ_q     <= '0;
      cnt_q     <= '0;
      res_x_q   <= '0;
      res_y_q   <= '0;
      res_w_q   <= '0;
      sent_q    <= '0;
      last_q    <= '0;
      rvalid_q  <= 1'b0;
      valid_q   <= 1'b0;
      accepts_q <= 1'b0;
      moved_q   <= 1'b0;
      chg_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      p_q       <= p_d;
      occ_q     <= occ_d;
      cnt_q     <= cnt_d;
      res_x_q   <= res_x_d;
      res_y_q   <= res_y_d;
      res_w_q   <= res_w_d;
      sent_q    <= sent_d;
      last_q    <= last_d;
      rvalid_q  <= rvalid_d;
      valid_q   <= valid_d;
      accepts_q <= accepts_d;
      moved_q   <= moved_d;
      chg_q     <= chg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    sw_q     <= sw_d;
    btn_q    <= btn_d;
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    cw_q     <= cw_d;
    result_q <= result_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[wp_q] <= wdata;
    end
    rdata_q <= ring_q[p_q];
  end

  assign busy           = state_q != S_IDLE;
  assign result_valid_o = valid_q;
  assign result_o       = result_q;

`include "mouse_motion_coalescer_top_assert.svh"

  `MMC_ASSERT_NOW(a_report_after_finish, valid_q, $past(state_q) == S_FINISH)
  `MMC_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= OCC_FULL)
  `MMC_ASSERT_NOW(a_walk_count, state_q == S_WALK, cnt_q <= occ_q)
  `MMC_ASSERT_NOW(a_ptr_range, 1'b1, wp_q <= PTR_LAST && rp_q <= PTR_LAST && p_q <= PTR_LAST)
  `MMC_ASSERT_NEXT(a_send_walks, accept && item_i.command == CMD_SEND && item_i.link_connected && occ_q != '0, state_q == S_WALK && busy)

endmodule

`default_nettype wire
